// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with async reset rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/tschc_pkg.sv =====
// ---------------------------------------------------------------------------
// tschc_pkg
// types and constants of the two-stage climate hysteresis controller
// ---------------------------------------------------------------------------
package tschc_pkg;

    localparam int NUM_LEVELS = 8;
    localparam int IDX_W      = 3;

    typedef logic signed [10:0] temp_t;
    typedef logic        [9:0]  hum_t;
    typedef logic signed [12:0] tsum_t;
    typedef logic        [11:0] hsum_t;
    typedef logic        [1:0]  drive_t;
    typedef logic        [1:0]  mode_t;

    // level register indexes
    localparam logic [IDX_W-1:0] LVL_HEAT_ON      = 3'd0;
    localparam logic [IDX_W-1:0] LVL_HEAT_BOOST   = 3'd1;
    localparam logic [IDX_W-1:0] LVL_HEAT_UNBOOST = 3'd2;
    localparam logic [IDX_W-1:0] LVL_HEAT_OFF     = 3'd3;
    localparam logic [IDX_W-1:0] LVL_COOL_ON      = 3'd4;
    localparam logic [IDX_W-1:0] LVL_COOL_BOOST   = 3'd5;
    localparam logic [IDX_W-1:0] LVL_COOL_UNBOOST = 3'd6;
    localparam logic [IDX_W-1:0] LVL_COOL_OFF     = 3'd7;

    // reset values of the level registers, already scaled by three
    localparam tsum_t LVL3_RESET [NUM_LEVELS] = '{
        13'sd600, 13'sd450, 13'sd510, 13'sd690,
        13'sd960, 13'sd1140, 13'sd1050, 13'sd840
    };

    localparam mode_t MODE_IDLE = 2'd0;
    localparam mode_t MODE_HEAT = 2'd1;
    localparam mode_t MODE_COOL = 2'd2;

    localparam drive_t DRIVE_OFF  = 2'd0;
    localparam drive_t DRIVE_LOW  = 2'd1;
    localparam drive_t DRIVE_HIGH = 2'd2;

    // humidifier thresholds on the sum of three readings
    localparam hsum_t HUM_ON_SUM      = 12'd2400;
    localparam hsum_t HUM_OFF_SUM     = 12'd2550;
    localparam hsum_t HUM_BOOST_SUM   = 12'd2100;
    localparam hsum_t HUM_UNBOOST_SUM = 12'd2250;

endpackage

// ===== src/two_stage_climate_hysteresis_controller.sv =====
// ---------------------------------------------------------------------------
// two_stage_climate_hysteresis_controller
// throughput: one request per cycle while the result register is not held back
// by out_ready; sums are taken into the input register, compares and stage
// updates run between it and the result register
// reset: modes idle, stages low, level registers back to their defaults
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module two_stage_climate_hysteresis_controller
    import tschc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [10:0]       cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  temp_t             temp_first,
    input  temp_t             temp_second,
    input  temp_t             temp_third,
    input  hum_t              hum_first,
    input  hum_t              hum_second,
    input  hum_t              hum_third,
    input  logic              sensor_fault,

    output logic              out_valid,
    input  logic              out_ready,
    output drive_t            heater_drive,
    output drive_t            cooler_drive,
    output drive_t            humidifier_drive
);

    tsum_t  lvl3_reg [NUM_LEVELS];
    tsum_t  cfg_ext;
    tsum_t  cfg_times3;

    logic   s1_valid_reg;
    tsum_t  ts_reg;
    hsum_t  hs_reg;
    tsum_t  ts_in;
    hsum_t  hs_in;

    mode_t  mode_reg;
    logic   heat_stage_reg;
    logic   cool_stage_reg;
    logic   humid_active_reg;
    logic   humid_stage_reg;
    mode_t  mode_next;
    logic   heat_stage_next;
    logic   cool_stage_next;
    logic   humid_active_next;
    logic   humid_stage_next;

    logic   out_valid_reg;
    drive_t heat_drive_reg;
    drive_t cool_drive_reg;
    drive_t humid_drive_reg;
    drive_t heat_drive_next;
    drive_t cool_drive_next;
    drive_t humid_drive_next;

    logic   advance;
    logic   in_fire;

    // level registers, stored as three times the written value
    assign cfg_ext    = {{2{cfg_data[10]}}, cfg_data};
    assign cfg_times3 = cfg_ext + {cfg_ext[11:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                lvl3_reg[i] <= LVL3_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            lvl3_reg[cfg_index] <= cfg_times3;
        end
    end

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign ts_in = {{2{temp_first[10]}}, temp_first}
                 + {{2{temp_second[10]}}, temp_second}
                 + {{2{temp_third[10]}}, temp_third};
    assign hs_in = {2'b00, hum_first} + {2'b00, hum_second} + {2'b00, hum_third};

    // input register, faulty requests are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid && !sensor_fault;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ts_reg <= ts_in;
            hs_reg <= hs_in;
        end
    end

    // mode and stage update
    always_comb
    begin
        mode_next         = mode_reg;
        heat_stage_next   = heat_stage_reg;
        cool_stage_next   = cool_stage_reg;
        humid_active_next = humid_active_reg;
        humid_stage_next  = humid_stage_reg;
        heat_drive_next   = DRIVE_OFF;
        cool_drive_next   = DRIVE_OFF;
        humid_drive_next  = DRIVE_OFF;

        // idle entry, cooling wins when both hold
        if (mode_reg == MODE_IDLE)
        begin
            if (ts_reg <= lvl3_reg[LVL_HEAT_ON])
            begin
                mode_next       = MODE_HEAT;
                heat_stage_next = 1'b0;
            end
            if (ts_reg >= lvl3_reg[LVL_COOL_ON])
            begin
                mode_next       = MODE_COOL;
                cool_stage_next = 1'b0;
            end
        end

        case (mode_next)
            MODE_HEAT:
            begin
                heat_drive_next = heat_stage_next ? DRIVE_HIGH : DRIVE_LOW;
                if (!heat_stage_next)
                begin
                    if (ts_reg <= lvl3_reg[LVL_HEAT_BOOST])
                    begin
                        heat_stage_next = 1'b1;
                    end
                    else if (ts_reg >= lvl3_reg[LVL_HEAT_OFF])
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                else if (ts_reg >= lvl3_reg[LVL_HEAT_UNBOOST])
                begin
                    heat_stage_next = 1'b0;
                end
            end
            MODE_COOL:
            begin
                cool_drive_next = cool_stage_next ? DRIVE_HIGH : DRIVE_LOW;
                if (!cool_stage_next)
                begin
                    if (ts_reg >= lvl3_reg[LVL_COOL_BOOST])
                    begin
                        cool_stage_next = 1'b1;
                    end
                    else if (ts_reg <= lvl3_reg[LVL_COOL_OFF])
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                else if (ts_reg <= lvl3_reg[LVL_COOL_UNBOOST])
                begin
                    cool_stage_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // humidifier
        if (!humid_active_reg && (hs_reg <= HUM_ON_SUM))
        begin
            humid_active_next = 1'b1;
            humid_stage_next  = 1'b0;
        end

        if (humid_active_next)
        begin
            humid_drive_next = humid_stage_next ? DRIVE_HIGH : DRIVE_LOW;
            if (!humid_stage_next)
            begin
                if (hs_reg >= HUM_OFF_SUM)
                begin
                    humid_active_next = 1'b0;
                end
                else if (hs_reg <= HUM_BOOST_SUM)
                begin
                    humid_stage_next = 1'b1;
                end
            end
            else if (hs_reg >= HUM_UNBOOST_SUM)
            begin
                humid_stage_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            heat_stage_reg   <= 1'b0;
            cool_stage_reg   <= 1'b0;
            humid_active_reg <= 1'b0;
            humid_stage_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            heat_stage_reg   <= heat_stage_next;
            cool_stage_reg   <= cool_stage_next;
            humid_active_reg <= humid_active_next;
            humid_stage_reg  <= humid_stage_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            heat_drive_reg  <= heat_drive_next;
            cool_drive_reg  <= cool_drive_next;
            humid_drive_reg <= humid_drive_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign heater_drive     = heat_drive_reg;
    assign cooler_drive     = cool_drive_reg;
    assign humidifier_drive = humid_drive_reg;

    `ASSERT_SAME(a_no_heat_and_cool, out_valid_reg,
                 (heat_drive_reg == DRIVE_OFF) || (cool_drive_reg == DRIVE_OFF))
    `ASSERT_SAME(a_stall_only_when_full, !in_ready,
                 s1_valid_reg && out_valid_reg && !out_ready)
    `ASSERT_NEXT(a_state_holds, !advance,
                 $stable(mode_reg) && $stable(heat_stage_reg) && $stable(cool_stage_reg)
                 && $stable(humid_active_reg) && $stable(humid_stage_reg))
    `ASSERT_NEXT(a_result_from_input, advance, out_valid_reg)

endmodule
